// File: hw/rtl/assert_macros.svh
// Assertion macros for the queue RTL; clk and rst must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock outside reset.
`define DSQ_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DSQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DSQ_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dsq_pkg.sv
// Package of the delta sleep queue: sizes, codes and shared types.
`default_nettype none

package dsq_pkg;

  localparam int CAPACITY     = 16;
  localparam int TICK_W       = 16;
  localparam int ID_W         = 8;
  localparam int RESULT_LIMIT = 16;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_COUNT   = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] LIMIT_COUNT = CNT_W'(RESULT_LIMIT);

  localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [TICK_W-1:0] a;
    logic [TICK_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] res;
    logic              carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/dsq_in_if.sv
// Request channel of the delta sleep queue.
`default_nettype none

interface dsq_in_if;
  logic                          valid;
  logic                          ready;
  logic [dsq_pkg::MODE_W-1:0]    mode;
  logic [dsq_pkg::ID_W-1:0]      task_id;
  logic [dsq_pkg::TICK_W-1:0]    ticks;

  modport source (output valid, mode, task_id, ticks, input ready);
  modport sink (input valid, mode, task_id, ticks, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dsq_out_if.sv
// Result channel of the delta sleep queue.
`default_nettype none

interface dsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [dsq_pkg::STATUS_W-1:0]  status;
  logic [dsq_pkg::ID_W-1:0]      woken_id;
  logic                          last;
  logic [dsq_pkg::TICK_W-1:0]    head_remaining;
  logic [dsq_pkg::CNT_W-1:0]     queue_count;

  modport source (output valid, status, woken_id, last, head_remaining, queue_count,
                  input ready);
  modport sink (input valid, status, woken_id, last, head_remaining, queue_count,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/delta_sleep_queue_top.sv
// Delta sleep queue: ordered timer queue of task ids with relative delays.
//
// The queue holds up to CAPACITY sleeping task ids, sorted by wake time. Each
// entry stores its delay relative to the entry ahead of it, so the head delta is
// the time left for the head. A request word carries a mode: sleep inserts
// task_id after ticks ticks (rejected with status full when the queue is full),
// tick lowers the head delta by one (never below zero) and then wakes every head
// entry at zero, one result word each, in queue order, last set on the final
// one; pop removes the head early and folds its remaining delta into the new
// head, saturating at the tick maximum. Tick or pop on an empty queue gives
// status empty; a tick that wakes nothing gives status none. Mode 3 is ignored
// and produces no word. Every result word carries the head delta and entry
// count after the whole request. Entries live in two RAMs (delta, id) with a
// single read port and a registered read; one add/subtract unit does every
// compare, subtract, decrement and sum. Each RAM visit pairs a read state with
// a check or write state, and output stalls hold the sequencer. The RAMs need
// no clearing after reset, since only entries below the count are used. The
// request side is ready only between requests; the output register holds the
// final word of one request while the next request is taken.
`default_nettype none

`include "assert_macros.svh"

module delta_sleep_queue_top (
  input logic      clk,
  input logic      rst,
  dsq_in_if.sink   req,
  dsq_out_if.source rsp
);

  // sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_WALK_RD   = 5'd1;
  localparam logic [4:0] S_WALK_CHK  = 5'd2;
  localparam logic [4:0] S_SHIFT_RD  = 5'd3;
  localparam logic [4:0] S_SHIFT_WR  = 5'd4;
  localparam logic [4:0] S_INS_WR    = 5'd5;
  localparam logic [4:0] S_TICK_DEC  = 5'd6;
  localparam logic [4:0] S_SCAN_RD   = 5'd7;
  localparam logic [4:0] S_SCAN_CHK  = 5'd8;
  localparam logic [4:0] S_EMIT_RD   = 5'd9;
  localparam logic [4:0] S_EMIT_WAIT = 5'd10;
  localparam logic [4:0] S_CMP_RD    = 5'd11;
  localparam logic [4:0] S_CMP_WR    = 5'd12;
  localparam logic [4:0] S_POP_RD0   = 5'd13;
  localparam logic [4:0] S_POP_ID    = 5'd14;
  localparam logic [4:0] S_POP_RD1   = 5'd15;
  localparam logic [4:0] S_POP_SUM   = 5'd16;
  localparam logic [4:0] S_POP_FIX   = 5'd17;
  localparam logic [4:0] S_RESULT    = 5'd18;

  localparam int TW = dsq_pkg::TICK_W;
  localparam int IW = dsq_pkg::ID_W;
  localparam int XW = dsq_pkg::IDX_W;
  localparam int NW = dsq_pkg::CNT_W;

  // control state
  logic [4:0]    state;
  logic [NW-1:0] count;   // entries in the queue
  logic [TW-1:0] head;    // mirror of the head entry's delta, 0 when empty
  logic          out_valid;

  // working registers
  logic [dsq_pkg::MODE_W-1:0]   op;
  logic [TW-1:0]                t;       // ticks left on the insert walk
  logic [IW-1:0]                id_reg;
  logic [IW-1:0]                cur_id;  // id taken off by a pop
  logic [NW-1:0]                pos;     // insert place
  logic [NW-1:0]                k;       // sweep / emit index
  logic [NW-1:0]                n;       // entries woken this tick
  logic [dsq_pkg::STATUS_W-1:0] st;

  // output register payload
  logic [dsq_pkg::STATUS_W-1:0] out_status;
  logic [IW-1:0]                out_id;
  logic                         out_last;
  logic [TW-1:0]                out_head;
  logic [NW-1:0]                out_count;

  // RAM and ALU connections
  logic          delta_we, id_we;
  logic [XW-1:0] wr_addr, rd_addr;
  logic [TW-1:0] wr_delta, rd_delta;
  logic [IW-1:0] wr_id, rd_id;

  dsq_pkg::alu_req_t alu_req;
  dsq_pkg::alu_rsp_t alu_rsp;

  logic [NW-1:0] km1, kp1, kn;
  logic [TW-1:0] dec_val, sat_sum;
  logic          out_free, out_load, walk_more;

  assign km1 = k - 1'b1;
  assign kp1 = k + 1'b1;
  assign kn  = k + n;

  // decrement stops at zero; pop sum saturates
  assign dec_val   = (head == '0) ? '0 : alu_rsp.res;
  assign sat_sum   = alu_rsp.carry ? '1 : alu_rsp.res;
  // t > d: subtract without borrow and with a nonzero difference
  assign walk_more = alu_rsp.carry && (alu_rsp.res != '0);

  assign out_free = !out_valid || rsp.ready;
  assign out_load = ((state == S_RESULT) || (state == S_EMIT_WAIT)) && out_free;

  dsq_ram #(.WIDTH(TW), .DEPTH(dsq_pkg::CAPACITY)) u_delta_ram (
    .clk     (clk),
    .we      (delta_we),
    .wr_addr (wr_addr),
    .wr_data (wr_delta),
    .rd_addr (rd_addr),
    .rd_data (rd_delta)
  );

  dsq_ram #(.WIDTH(IW), .DEPTH(dsq_pkg::CAPACITY)) u_id_ram (
    .clk     (clk),
    .we      (id_we),
    .wr_addr (wr_addr),
    .wr_data (wr_id),
    .rd_addr (rd_addr),
    .rd_data (rd_id)
  );

  dsq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // RAM addressing and ALU operand selection per state
  always_comb begin
    alu_req  = '{a: t, b: rd_delta, sub: 1'b1};
    rd_addr  = k[XW-1:0];
    wr_addr  = k[XW-1:0];
    delta_we = 1'b0;
    id_we    = 1'b0;
    wr_delta = rd_delta;
    wr_id    = rd_id;
    unique case (state)
      S_WALK_RD: begin
        rd_addr = pos[XW-1:0];
      end
      S_SHIFT_RD: begin
        rd_addr = km1[XW-1:0];
      end
      S_SHIFT_WR: begin
        // the entry that lands right behind the new one gives up its remainder
        alu_req  = '{a: rd_delta, b: t, sub: 1'b1};
        delta_we = 1'b1;
        id_we    = 1'b1;
        wr_delta = (km1 == pos) ? alu_rsp.res : rd_delta;
      end
      S_INS_WR: begin
        delta_we = 1'b1;
        id_we    = 1'b1;
        wr_addr  = pos[XW-1:0];
        wr_delta = t;
        wr_id    = id_reg;
      end
      S_TICK_DEC: begin
        alu_req  = '{a: head, b: TW'(1), sub: 1'b1};
        delta_we = 1'b1;
        wr_addr  = '0;
        wr_delta = dec_val;
      end
      S_SCAN_RD: begin
        rd_addr = n[XW-1:0];
      end
      S_CMP_RD: begin
        rd_addr = kn[XW-1:0];
      end
      S_CMP_WR: begin
        delta_we = 1'b1;
        id_we    = 1'b1;
      end
      S_POP_RD0: begin
        rd_addr = '0;
      end
      S_POP_RD1: begin
        rd_addr = XW'(1);
      end
      S_POP_SUM: begin
        alu_req = '{a: rd_delta, b: head, sub: 1'b0};
      end
      S_POP_FIX: begin
        delta_we = 1'b1;
        wr_addr  = '0;
        wr_delta = head;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op     <= req.mode;
            t      <= req.ticks;
            id_reg <= req.task_id;
            pos    <= '0;
            k      <= count;
            unique case (req.mode)
              dsq_pkg::MODE_SLEEP: begin
                if (count == dsq_pkg::CAP_COUNT) begin
                  st    <= dsq_pkg::ST_FULL;
                  state <= S_RESULT;
                end else begin
                  state <= S_WALK_RD;
                end
              end
              dsq_pkg::MODE_TICK: begin
                if (count == '0) begin
                  st    <= dsq_pkg::ST_EMPTY;
                  state <= S_RESULT;
                end else begin
                  state <= S_TICK_DEC;
                end
              end
              dsq_pkg::MODE_POP: begin
                if (count == '0) begin
                  st    <= dsq_pkg::ST_EMPTY;
                  state <= S_RESULT;
                end else begin
                  state <= S_POP_RD0;
                end
              end
              default: ;  // unused mode: dropped
            endcase
          end
        end

        // insert: walk past entries while ticks exceed their delta
        S_WALK_RD: begin
          state <= (pos == count) ? S_SHIFT_RD : S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (walk_more) begin
            t     <= alu_rsp.res;
            pos   <= pos + 1'b1;
            state <= S_WALK_RD;
          end else begin
            state <= S_SHIFT_RD;
          end
        end
        // open a hole at pos, moving entries up from the tail
        S_SHIFT_RD: begin
          state <= (k == pos) ? S_INS_WR : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          k     <= km1;
          state <= S_SHIFT_RD;
        end
        S_INS_WR: begin
          count <= count + 1'b1;
          if (pos == '0) begin
            head <= t;
          end
          st    <= dsq_pkg::ST_INSERTED;
          state <= S_RESULT;
        end

        // tick: one decrement, then count leading zero deltas
        S_TICK_DEC: begin
          head <= dec_val;
          if (dec_val != '0) begin
            st    <= dsq_pkg::ST_NONE;
            state <= S_RESULT;
          end else begin
            n     <= NW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (n == count) begin
            head  <= '0;
            count <= '0;
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if ((rd_delta == '0) && (n < dsq_pkg::LIMIT_COUNT)) begin
            n     <= n + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            // all ahead are zero, so this relative delta is the new head's time
            head  <= rd_delta;
            count <= count - n;
            k     <= '0;
            state <= S_EMIT_RD;
          end
        end
        // emit woken ids before compaction overwrites them
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_free) begin
            if (kp1 == n) begin
              k     <= '0;
              state <= S_CMP_RD;
            end else begin
              k     <= kp1;
              state <= S_EMIT_RD;
            end
          end
        end

        // compaction: entry k+n moves to k for every remaining entry
        S_CMP_RD: begin
          if (k == count) begin
            state <= (op == dsq_pkg::MODE_POP) ? S_POP_FIX : S_IDLE;
          end else begin
            state <= S_CMP_WR;
          end
        end
        S_CMP_WR: begin
          k     <= kp1;
          state <= S_CMP_RD;
        end

        // pop: take the head id, fold its delta into the next entry
        S_POP_RD0: begin
          state <= S_POP_ID;
        end
        S_POP_ID: begin
          cur_id <= rd_id;
          if (count > NW'(1)) begin
            state <= S_POP_RD1;
          end else begin
            head  <= '0;
            count <= '0;
            st    <= dsq_pkg::ST_REMOVED;
            state <= S_RESULT;
          end
        end
        S_POP_RD1: begin
          state <= S_POP_SUM;
        end
        S_POP_SUM: begin
          head  <= sat_sum;
          n     <= NW'(1);
          count <= count - 1'b1;
          k     <= '0;
          state <= S_CMP_RD;
        end
        S_POP_FIX: begin
          st    <= dsq_pkg::ST_REMOVED;
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_head  <= head;
      out_count <= count;
      if (state == S_RESULT) begin
        out_status <= st;
        out_id     <= (st == dsq_pkg::ST_REMOVED) ? cur_id : '0;
        out_last   <= 1'b1;
      end else begin
        out_status <= dsq_pkg::ST_WOKEN;
        out_id     <= rd_id;
        out_last   <= (kp1 == n);
      end
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.woken_id       = out_id;
  assign rsp.last           = out_last;
  assign rsp.head_remaining = out_head;
  assign rsp.queue_count    = out_count;

  `DSQ_CHECK(a_count_bound, count <= dsq_pkg::CAP_COUNT, "entry count above capacity")
  `DSQ_IMPLY(a_empty_head, (state == S_IDLE) && (count == '0), head == '0, "empty, head nonzero")
  `DSQ_IMPLY(a_scan_bound, state == S_SCAN_CHK, n < count, "wake scan read past the tail")
  `DSQ_NEXT(a_insert_grows, state == S_INS_WR, count == $past(count) + 1'b1, "insert missed count")

endmodule

`default_nettype wire

// File: hw/rtl/dsq_ram.sv
// Generic simple dual-port RAM, one write port, registered read port.
`default_nettype none

module dsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/dsq_alu.sv
// Shared add/subtract unit; carry out doubles as "no borrow" on subtract.
`default_nettype none

module dsq_alu (
  input  dsq_pkg::alu_req_t req,
  output dsq_pkg::alu_rsp_t rsp
);

  logic [dsq_pkg::TICK_W:0]   sum;
  logic [dsq_pkg::TICK_W-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{dsq_pkg::TICK_W{1'b0}}, req.sub};

  assign rsp.res   = sum[dsq_pkg::TICK_W-1:0];
  assign rsp.carry = sum[dsq_pkg::TICK_W];

endmodule

`default_nettype wire
